### design/qphs_pkg.sv
package qphs_pkg;

    // Sizes of the stores.
    localparam int MAX_BUCKETS   = 256;
    localparam int HEAP_BYTES    = 4096;
    localparam int MAX_KEY_BYTES = 64;

    localparam int BKT_W   = $clog2(MAX_BUCKETS);
    localparam int NB_W    = BKT_W + 1;
    localparam int HEAP_AW = $clog2(HEAP_BYTES);
    localparam int CAP_W   = HEAP_AW + 1;
    localparam int KEY_AW  = $clog2(MAX_KEY_BYTES);
    localparam int LEN_W   = KEY_AW + 1;
    localparam int HASH_W  = 32;
    localparam int HASH_CW = $clog2(HASH_W);

    // Configuration port.
    localparam int CFG_NB_W  = 9;
    localparam int CFG_CAP_W = 13;
    localparam int CFG_DW    = 13;
    localparam int CFG_IW    = 1;
    localparam logic [CFG_IW-1:0] CFG_BUCKET_COUNT  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_HEAP_CAPACITY = 1'b1;
    localparam logic [CFG_NB_W-1:0]  NB_RESET  = 9'd256;
    localparam logic [CFG_CAP_W-1:0] CAP_RESET = 13'd4096;
    localparam logic [CAP_W-1:0]     CAP_MIN   = CAP_W'(2);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MOD,
        S_PROBE,
        S_OFF,
        S_CMP_RD,
        S_CMP_CHK,
        S_CPY_RD,
        S_CPY_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    intake_en;
        logic    key_clear;
        logic    mod_start;
        logic    mod_step;
        logic    next_probe;
        logic    claim;
        logic    off_rd;
        logic    off_load;
        logic    cmp_rd;
        logic    k_inc;
        logic    cpy_rd;
        logic    cpy_wr;
        logic    ap_advance;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic last_fire;
        logic too_long;
        logic req_find;
        logic room_ok;
        logic mod_last;
        logic bucket_used;
        logic probe_last;
        logic past_cap;
        logic byte_eq;
        logic k_last;
        logic out_busy;
    } sts_t;

endpackage

### design/qphs_ram.sv
module qphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/qphs_ctrl.sv
module qphs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  qphs_pkg::sts_t sts,
    output qphs_pkg::cmd_t cmd
);

    qphs_pkg::state_t  state_reg, state_next;
    qphs_pkg::status_t status_reg, status_next;

    // State and result code registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= qphs_pkg::S_IDLE;
            status_reg <= qphs_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // Next state and the result code to report.
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            qphs_pkg::S_IDLE:
            begin
                if (sts.last_fire)
                begin
                    if (sts.too_long)
                    begin
                        status_next = qphs_pkg::ST_TOO_LONG;
                        state_next  = qphs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = qphs_pkg::S_START;
                    end
                end
            end
            qphs_pkg::S_START:
            begin
                if (!sts.req_find && !sts.room_ok)
                begin
                    status_next = qphs_pkg::ST_NO_SPACE;
                    state_next  = qphs_pkg::S_DONE;
                end
                else
                begin
                    state_next = qphs_pkg::S_MOD;
                end
            end
            qphs_pkg::S_MOD:
            begin
                if (sts.mod_last)
                begin
                    state_next = qphs_pkg::S_PROBE;
                end
            end
            qphs_pkg::S_PROBE:
            begin
                if (!sts.req_find)
                begin
                    if (!sts.bucket_used)
                    begin
                        state_next = qphs_pkg::S_CPY_RD;
                    end
                    else if (sts.probe_last)
                    begin
                        status_next = qphs_pkg::ST_FULL;
                        state_next  = qphs_pkg::S_DONE;
                    end
                end
                else if (!sts.bucket_used)
                begin
                    status_next = qphs_pkg::ST_NOT_FOUND;
                    state_next  = qphs_pkg::S_DONE;
                end
                else
                begin
                    state_next = qphs_pkg::S_OFF;
                end
            end
            qphs_pkg::S_OFF:
            begin
                state_next = qphs_pkg::S_CMP_RD;
            end
            qphs_pkg::S_CMP_RD:
            begin
                if (sts.past_cap)
                begin
                    if (sts.probe_last)
                    begin
                        status_next = qphs_pkg::ST_NOT_FOUND;
                        state_next  = qphs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = qphs_pkg::S_PROBE;
                    end
                end
                else
                begin
                    state_next = qphs_pkg::S_CMP_CHK;
                end
            end
            qphs_pkg::S_CMP_CHK:
            begin
                if (!sts.byte_eq)
                begin
                    if (sts.probe_last)
                    begin
                        status_next = qphs_pkg::ST_NOT_FOUND;
                        state_next  = qphs_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = qphs_pkg::S_PROBE;
                    end
                end
                else if (sts.k_last)
                begin
                    status_next = qphs_pkg::ST_OK;
                    state_next  = qphs_pkg::S_DONE;
                end
                else
                begin
                    state_next = qphs_pkg::S_CMP_RD;
                end
            end
            qphs_pkg::S_CPY_RD:
            begin
                state_next = qphs_pkg::S_CPY_WR;
            end
            qphs_pkg::S_CPY_WR:
            begin
                if (sts.k_last)
                begin
                    status_next = qphs_pkg::ST_OK;
                    state_next  = qphs_pkg::S_DONE;
                end
                else
                begin
                    state_next = qphs_pkg::S_CPY_RD;
                end
            end
            qphs_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = qphs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qphs_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd            = '0;
        cmd.out_status = status_reg;
        unique case (state_reg)
            qphs_pkg::S_IDLE:
            begin
                cmd.intake_en = 1'b1;
            end
            qphs_pkg::S_START:
            begin
                cmd.mod_start = sts.req_find || sts.room_ok;
            end
            qphs_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
            end
            qphs_pkg::S_PROBE:
            begin
                if (!sts.req_find)
                begin
                    cmd.claim      = !sts.bucket_used;
                    cmd.next_probe = sts.bucket_used && !sts.probe_last;
                end
                else
                begin
                    cmd.off_rd = sts.bucket_used;
                end
            end
            qphs_pkg::S_OFF:
            begin
                cmd.off_load = 1'b1;
            end
            qphs_pkg::S_CMP_RD:
            begin
                cmd.cmp_rd     = !sts.past_cap;
                cmd.next_probe = sts.past_cap && !sts.probe_last;
            end
            qphs_pkg::S_CMP_CHK:
            begin
                cmd.next_probe = !sts.byte_eq && !sts.probe_last;
                cmd.k_inc      = sts.byte_eq && !sts.k_last;
            end
            qphs_pkg::S_CPY_RD:
            begin
                cmd.cpy_rd = 1'b1;
            end
            qphs_pkg::S_CPY_WR:
            begin
                cmd.cpy_wr     = 1'b1;
                cmd.ap_advance = sts.k_last;
                cmd.k_inc      = !sts.k_last;
            end
            qphs_pkg::S_DONE:
            begin
                cmd.out_load  = !sts.out_busy;
                cmd.key_clear = !sts.out_busy;
            end
            default:
            begin
                cmd.intake_en = 1'b0;
            end
        endcase
    end

endmodule

### design/qphs_dp.sv
module qphs_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qphs_pkg::cmd_t                   cmd,
    output qphs_pkg::sts_t                   sts,
    input  logic                             in_valid,
    input  logic                             req_type,
    input  logic [7:0]                       data_byte,
    input  logic                             last_byte,
    input  logic [qphs_pkg::HASH_W-1:0]      hash_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       status,
    input  logic                             cfg_we,
    input  logic [qphs_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [qphs_pkg::CFG_DW-1:0]      cfg_data
);

    logic [qphs_pkg::CFG_NB_W-1:0]  nb_cfg_reg;
    logic [qphs_pkg::CFG_CAP_W-1:0] cap_cfg_reg;
    logic [qphs_pkg::NB_W-1:0]      nb_eff;
    logic [qphs_pkg::CAP_W-1:0]     cap_eff;

    logic                           fire;
    logic [qphs_pkg::LEN_W-1:0]     len_reg;
    logic                           ovf_reg;
    logic                           req_reg;
    logic [qphs_pkg::HASH_W-1:0]    hash_sh_reg;
    logic [qphs_pkg::HASH_CW-1:0]   mod_cnt_reg;
    logic [qphs_pkg::BKT_W-1:0]     idx_reg, idx_next;
    logic [qphs_pkg::BKT_W-1:0]     i_reg;
    logic [qphs_pkg::NB_W-1:0]      mod_t;
    logic [qphs_pkg::NB_W-1:0]      inc;
    logic [qphs_pkg::NB_W:0]        probe_sum;
    logic [qphs_pkg::MAX_BUCKETS-1:0] valid_reg;
    logic [qphs_pkg::CAP_W-1:0]     ap_reg;
    logic [qphs_pkg::HEAP_AW-1:0]   off_reg;
    logic [qphs_pkg::KEY_AW-1:0]    k_reg;
    logic [qphs_pkg::CAP_W-1:0]     cmp_addr;
    logic [qphs_pkg::CAP_W-1:0]     cmp_addr_reg;
    logic [qphs_pkg::CAP_W-1:0]     cpy_addr;
    logic [qphs_pkg::HEAP_AW-1:0]   bkt_rdata;
    logic [7:0]                     kbuf_rdata;
    logic [7:0]                     heap_rdata;
    logic [7:0]                     heap_byte;
    logic                           out_valid_reg;
    logic [2:0]                     status_reg;

    // Configuration registers and their clamped values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_cfg_reg  <= qphs_pkg::NB_RESET;
            cap_cfg_reg <= qphs_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == qphs_pkg::CFG_BUCKET_COUNT)
            begin
                nb_cfg_reg <= cfg_data[qphs_pkg::CFG_NB_W-1:0];
            end
            else
            begin
                cap_cfg_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (nb_cfg_reg == '0)
        begin
            nb_eff = qphs_pkg::NB_W'(1);
        end
        else if (32'(nb_cfg_reg) > qphs_pkg::MAX_BUCKETS)
        begin
            nb_eff = qphs_pkg::NB_W'(qphs_pkg::MAX_BUCKETS);
        end
        else
        begin
            nb_eff = qphs_pkg::NB_W'(nb_cfg_reg);
        end
        if (qphs_pkg::CAP_W'(cap_cfg_reg) < qphs_pkg::CAP_MIN)
        begin
            cap_eff = qphs_pkg::CAP_MIN;
        end
        else if (32'(cap_cfg_reg) > qphs_pkg::HEAP_BYTES)
        begin
            cap_eff = qphs_pkg::CAP_W'(qphs_pkg::HEAP_BYTES);
        end
        else
        begin
            cap_eff = qphs_pkg::CAP_W'(cap_cfg_reg);
        end
    end

    // Key intake: bytes beyond the buffer only raise the overflow flag.
    assign fire = in_valid && cmd.intake_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cmd.key_clear)
        begin
            len_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (32'(len_reg) < qphs_pkg::MAX_KEY_BYTES)
            begin
                len_reg <= len_reg + qphs_pkg::LEN_W'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last_byte)
        begin
            req_reg <= req_type;
        end
    end

    // Hash reduction one bit a cycle, then triangular probe stepping.
    assign mod_t     = {idx_reg, hash_sh_reg[qphs_pkg::HASH_W-1]};
    assign inc       = qphs_pkg::NB_W'(i_reg) + qphs_pkg::NB_W'(1);
    assign probe_sum = (qphs_pkg::NB_W+1)'(idx_reg) + (qphs_pkg::NB_W+1)'(inc);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.mod_start)
        begin
            idx_next = '0;
        end
        else if (cmd.mod_step)
        begin
            if (mod_t >= nb_eff)
            begin
                idx_next = qphs_pkg::BKT_W'(mod_t - nb_eff);
            end
            else
            begin
                idx_next = qphs_pkg::BKT_W'(mod_t);
            end
        end
        else if (cmd.next_probe)
        begin
            if (probe_sum >= (qphs_pkg::NB_W+1)'(nb_eff))
            begin
                idx_next = qphs_pkg::BKT_W'(probe_sum - (qphs_pkg::NB_W+1)'(nb_eff));
            end
            else
            begin
                idx_next = qphs_pkg::BKT_W'(probe_sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (fire && last_byte)
        begin
            hash_sh_reg <= hash_value;
        end
        else if (cmd.mod_step)
        begin
            hash_sh_reg <= {hash_sh_reg[qphs_pkg::HASH_W-2:0], 1'b0};
        end
        if (cmd.mod_start)
        begin
            mod_cnt_reg <= '0;
            i_reg       <= '0;
        end
        else
        begin
            if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + qphs_pkg::HASH_CW'(1);
            end
            if (cmd.next_probe)
            begin
                i_reg <= i_reg + qphs_pkg::BKT_W'(1);
            end
        end
    end

    // Bucket occupancy flags and the heap append point.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ap_reg    <= qphs_pkg::CAP_W'(1);
        end
        else
        begin
            if (cmd.claim)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.ap_advance)
            begin
                ap_reg <= ap_reg + qphs_pkg::CAP_W'(len_reg);
            end
        end
    end

    // Byte counter and the stored offset under comparison.
    always_ff @(posedge clk)
    begin
        if (cmd.claim || cmd.off_load)
        begin
            k_reg <= '0;
        end
        else if (cmd.k_inc)
        begin
            k_reg <= k_reg + qphs_pkg::KEY_AW'(1);
        end
        if (cmd.off_load)
        begin
            off_reg <= bkt_rdata;
        end
        if (cmd.cmp_rd)
        begin
            cmp_addr_reg <= cmp_addr;
        end
    end

    assign cmp_addr = qphs_pkg::CAP_W'(off_reg) + qphs_pkg::CAP_W'(k_reg);
    assign cpy_addr = ap_reg + qphs_pkg::CAP_W'(k_reg);

    // Heap bytes at or past the append point were never written and read as zero.
    assign heap_byte = (cmp_addr_reg < ap_reg) ? heap_rdata : 8'd0;

    qphs_ram #(
        .WIDTH (8),
        .DEPTH (qphs_pkg::MAX_KEY_BYTES)
    ) u_kbuf (
        .clk   (clk),
        .we    (fire && (32'(len_reg) < qphs_pkg::MAX_KEY_BYTES)),
        .waddr (len_reg[qphs_pkg::KEY_AW-1:0]),
        .wdata (data_byte),
        .re    (cmd.cmp_rd || cmd.cpy_rd),
        .raddr (k_reg),
        .rdata (kbuf_rdata)
    );

    qphs_ram #(
        .WIDTH (qphs_pkg::HEAP_AW),
        .DEPTH (qphs_pkg::MAX_BUCKETS)
    ) u_bkt (
        .clk   (clk),
        .we    (cmd.claim),
        .waddr (idx_reg),
        .wdata (ap_reg[qphs_pkg::HEAP_AW-1:0]),
        .re    (cmd.off_rd),
        .raddr (idx_reg),
        .rdata (bkt_rdata)
    );

    qphs_ram #(
        .WIDTH (8),
        .DEPTH (qphs_pkg::HEAP_BYTES)
    ) u_heap (
        .clk   (clk),
        .we    (cmd.cpy_wr),
        .waddr (cpy_addr[qphs_pkg::HEAP_AW-1:0]),
        .wdata (kbuf_rdata),
        .re    (cmd.cmp_rd),
        .raddr (cmp_addr[qphs_pkg::HEAP_AW-1:0]),
        .rdata (heap_rdata)
    );

    // Output register: the result item waits here until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // Status to the controller.
    always_comb
    begin
        sts.last_fire   = fire && last_byte;
        sts.too_long    = ovf_reg || (32'(len_reg) == qphs_pkg::MAX_KEY_BYTES);
        sts.req_find    = req_reg;
        sts.room_ok     = (ap_reg < cap_eff)
                          && ((cap_eff - ap_reg) > qphs_pkg::CAP_W'(len_reg));
        sts.mod_last    = (mod_cnt_reg == qphs_pkg::HASH_CW'(qphs_pkg::HASH_W - 1));
        sts.bucket_used = valid_reg[idx_reg];
        sts.probe_last  = (qphs_pkg::NB_W'(i_reg) == (nb_eff - qphs_pkg::NB_W'(1)));
        sts.past_cap    = (cmp_addr >= cap_eff);
        sts.byte_eq     = (heap_byte == kbuf_rdata);
        sts.k_last      = ((qphs_pkg::LEN_W'(k_reg) + qphs_pkg::LEN_W'(1)) == len_reg);
        sts.out_busy    = out_valid_reg && !out_ready;
    end

    // A bucket is claimed only while empty.
    a_claim_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim |-> !valid_reg[idx_reg])
        else $error("bucket claimed twice");

    // The probe index stays below the bucket count while probing.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.next_probe |=> (qphs_pkg::NB_W'(idx_reg) < nb_eff))
        else $error("probe index out of range");

    // The append point never runs past the heap.
    a_ap_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ap_reg) <= qphs_pkg::HEAP_BYTES)
        else $error("append point beyond heap");

    // A result is loaded only into a free output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");

endmodule

### design/quadratic_probe_hash_set.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   req_type, data_byte, last_byte, hash_value
// output    out_valid / out_ready status
// config    cfg_we                cfg_index, cfg_data
//
// A key byte that is not the last is taken whenever the block waits for key bytes.
// A last byte starts the bit-serial hash reduction, then the probes: an add checks bucket
// flags until a free one and copies the key into the heap byte by byte; a find reads the
// stored offset per probe and compares the key with the heap byte by byte.
// No clearing pass after reset: bucket flags reset at once, the heap uses a fill mark.
// A result waits in the output register; the block stalls only if a second result is due.
module quadratic_probe_hash_set (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,
    input  logic [qphs_pkg::HASH_W-1:0]       hash_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        status,
    input  logic                              cfg_we,
    input  logic [qphs_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [qphs_pkg::CFG_DW-1:0]       cfg_data
);

    qphs_pkg::cmd_t cmd;
    qphs_pkg::sts_t sts;

    // Items are taken only while the controller waits for key bytes.
    assign in_ready = cmd.intake_en;

    qphs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    qphs_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_valid   (in_valid),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .hash_value (hash_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

endmodule

### sim/quadratic_probe_hash_set_checker.sv
module quadratic_probe_hash_set_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            req_type,
    input  logic [7:0]                      data_byte,
    input  logic                            last_byte,
    input  logic [qphs_pkg::HASH_W-1:0]     hash_value,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [2:0]                      status,
    input  logic                            cfg_we,
    input  logic [qphs_pkg::CFG_IW-1:0]     cfg_index,
    input  logic [qphs_pkg::CFG_DW-1:0]     cfg_data,
    output int                              error_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the set: registers, buckets, heap and the key being gathered.
    logic [qphs_pkg::CFG_NB_W-1:0]  nb_reg;
    logic [qphs_pkg::CFG_CAP_W-1:0] cap_reg;
    int unsigned                    slot_offset [qphs_pkg::MAX_BUCKETS];
    logic [7:0]                     heap_byte [qphs_pkg::HEAP_BYTES];
    int unsigned                    append_at;
    logic [7:0]                     key_bytes [qphs_pkg::MAX_KEY_BYTES];
    int unsigned                    key_len;
    bit                             key_long;
    qphs_pkg::status_t              expected_status [$];

    function automatic int unsigned used_buckets();
        if (nb_reg == 0) return 1;
        if (nb_reg > qphs_pkg::MAX_BUCKETS) return qphs_pkg::MAX_BUCKETS;
        return nb_reg;
    endfunction

    function automatic int unsigned used_capacity();
        if (cap_reg < 2) return 2;
        if (cap_reg > qphs_pkg::HEAP_BYTES) return qphs_pkg::HEAP_BYTES;
        return cap_reg;
    endfunction

    function automatic int unsigned slot_of(logic [31:0] h, int unsigned i, int unsigned nb);
        longint unsigned tri_num;
        tri_num = (longint'(i) * (longint'(i) + 1)) / 2;
        return int'((longint'(h) + tri_num) % longint'(nb));
    endfunction

    // Adds the gathered key to the set and returns the status it earns.
    function automatic qphs_pkg::status_t insert_key(logic [31:0] h);
        int unsigned cap;
        int unsigned nb;
        int unsigned room;
        int unsigned idx;
        cap  = used_capacity();
        nb   = used_buckets();
        room = (append_at < cap) ? cap - append_at : 0;
        if (!(room > key_len)) return qphs_pkg::ST_NO_SPACE;
        for (int unsigned i = 0; i < nb; i++)
        begin
            idx = slot_of(h, i, nb);
            if (slot_offset[idx] == 0)
            begin
                slot_offset[idx] = append_at;
                for (int unsigned k = 0; k < key_len; k++)
                    heap_byte[append_at + k] = key_bytes[k];
                append_at += key_len;
                return qphs_pkg::ST_OK;
            end
        end
        return qphs_pkg::ST_FULL;
    endfunction

    // Looks the gathered key up with a prefix compare against the heap.
    function automatic qphs_pkg::status_t lookup_key(logic [31:0] h);
        int unsigned cap;
        int unsigned nb;
        int unsigned off;
        bit          same;
        cap = used_capacity();
        nb  = used_buckets();
        for (int unsigned i = 0; i < nb; i++)
        begin
            off = slot_offset[slot_of(h, i, nb)];
            if (off == 0) return qphs_pkg::ST_NOT_FOUND;
            same = 1'b1;
            for (int unsigned k = 0; k < key_len; k++)
            begin
                if (off + k >= cap || heap_byte[off + k] != key_bytes[k])
                begin
                    same = 1'b0;
                    break;
                end
            end
            if (same) return qphs_pkg::ST_OK;
        end
        return qphs_pkg::ST_NOT_FOUND;
    endfunction

    assign pending_count = expected_status.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg      = qphs_pkg::NB_RESET;
            cap_reg     = qphs_pkg::CAP_RESET;
            append_at   = 1;
            key_len     = 0;
            key_long    = 1'b0;
            error_count = 0;
            expected_status.delete();
            foreach (slot_offset[i]) slot_offset[i] = 0;
            foreach (heap_byte[i]) heap_byte[i] = 8'd0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                if (cfg_index == qphs_pkg::CFG_BUCKET_COUNT)
                    nb_reg = cfg_data[qphs_pkg::CFG_NB_W-1:0];
                else if (cfg_index == qphs_pkg::CFG_HEAP_CAPACITY)
                    cap_reg = cfg_data;
            end
            // Accepted input item.
            if (in_valid && in_ready)
            begin
                if (key_len < qphs_pkg::MAX_KEY_BYTES)
                begin
                    key_bytes[key_len] = data_byte;
                    key_len++;
                end
                else
                    key_long = 1'b1;
                if (last_byte)
                begin
                    if (key_long) expected_status.push_back(qphs_pkg::ST_TOO_LONG);
                    else if (req_type == 1'b0) expected_status.push_back(insert_key(hash_value));
                    else expected_status.push_back(lookup_key(hash_value));
                    key_len  = 0;
                    key_long = 1'b0;
                end
            end
            // Accepted result item.
            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Unexpected result: status %0d", status);
                end
                else if (status !== expected_status[0])
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("Status mismatch: expected %0d, got %0d",
                                 expected_status[0], status);
                    void'(expected_status.pop_front());
                end
                else
                    void'(expected_status.pop_front());
            end
        end
    end
endmodule

### sim/quadratic_probe_hash_set_tb.sv
module quadratic_probe_hash_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_KEYS    = 420;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            req_type = 1'b0;
    logic [7:0]                      data_byte = 8'd0;
    logic                            last_byte = 1'b0;
    logic [qphs_pkg::HASH_W-1:0]     hash_value = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [2:0]                      status;
    logic                            cfg_we = 1'b0;
    logic [qphs_pkg::CFG_IW-1:0]     cfg_index = qphs_pkg::CFG_BUCKET_COUNT;
    logic [qphs_pkg::CFG_DW-1:0]     cfg_data = '0;
    int                              error_count;
    int                              pending_count;
    bit                              calm_tail = 1'b0;
    bit                              hold_sink = 1'b0;
    int                              quiet_cycles = 0;

    // Keys kept for later lookups, so finds hit stored entries.
    logic [7:0]  saved_key [16][$];
    logic [31:0] saved_hash [16];
    int          saved_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    quadratic_probe_hash_set dut (.*);

    quadratic_probe_hash_set_checker checker_i (.*);

    // Watchdog on cycles with no accepted item in either direction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none near the end.
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 15);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_byte(bit op, logic [7:0] b, bit fin, logic [31:0] h);
        int gap;
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= op;
        data_byte <= b;
        last_byte <= fin;
        hash_value <= h;
        do @(posedge clk); while (!in_ready);
    endtask

    // The valid line is left to the next byte or to the caller once the key is sent.
    task automatic send_key(bit op, logic [7:0] bytes [$], logic [31:0] h);
        for (int k = 0; k < bytes.size(); k++)
            send_byte(op, bytes[k], k == bytes.size() - 1, h);
    endtask

    task automatic random_key(output logic [7:0] bytes [$], input int maxlen);
        int n;
        bytes = {};
        n = $urandom_range(1, maxlen);
        for (int k = 0; k < n; k++) bytes.push_back(8'($urandom));
    endtask

    // Waits for all results, then lets the block settle before a register write.
    task automatic settle_and_write(logic [qphs_pkg::CFG_IW-1:0] idx,
                                    logic [qphs_pkg::CFG_DW-1:0] val);
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One phase of random keys: mostly adds and finds of stored keys.
    task automatic random_phase(int keys, int maxlen, logic [31:0] hmask);
        logic [7:0]  bytes [$];
        logic [31:0] h;
        int          pick;
        int          sel;
        for (int n = 0; n < keys; n++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4 || saved_count == 0)
            begin
                random_key(bytes, maxlen);
                h = $urandom & hmask;
                send_key(1'b0, bytes, h);
                sel = saved_count % 16;
                saved_key[sel] = bytes;
                saved_hash[sel] = h;
                saved_count++;
            end
            else if (pick < 8)
            begin
                sel = $urandom_range(0, (saved_count < 16 ? saved_count : 16) - 1);
                bytes = saved_key[sel];
                // A shortened needle exercises the prefix compare.
                if (bytes.size() > 1 && $urandom_range(0, 3) == 0)
                    bytes = bytes[0:$urandom_range(0, bytes.size() - 1)];
                send_key(1'b1, bytes, saved_hash[sel]);
            end
            else
            begin
                random_key(bytes, maxlen);
                if ($urandom_range(0, 15) == 0)
                    for (int k = 0; k < 8; k++) bytes.push_back(8'($urandom));
                send_key(1'($urandom_range(0, 1)), bytes, $urandom);
            end
        end
    endtask

    initial
    begin
        logic [7:0] bytes [$];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of bytes and hashes, both operations, long keys.
        send_key(1'b1, '{8'h00}, 32'h0);
        send_key(1'b0, '{8'h00}, 32'h0);
        send_key(1'b0, '{8'hFF, 8'h00, 8'hA5}, 32'hFFFF_FFFF);
        send_key(1'b1, '{8'hFF, 8'h00, 8'hA5}, 32'hFFFF_FFFF);
        send_key(1'b1, '{8'hFF, 8'h00}, 32'hFFFF_FFFF);
        send_key(1'b1, '{8'hFF, 8'h00, 8'hA5, 8'h00}, 32'hFFFF_FFFF);
        send_key(1'b1, '{8'h5A}, 32'h8000_0000);
        bytes = {};
        for (int k = 0; k < qphs_pkg::MAX_KEY_BYTES; k++) bytes.push_back(8'(k * 37));
        send_key(1'b0, bytes, 32'h1234_5678);
        send_key(1'b1, bytes, 32'h1234_5678);
        bytes.push_back(8'h55);
        send_key(1'b0, bytes, 32'h0);

        // Receiver holds off while keys keep coming, filling the block.
        hold_sink = 1'b1;
        random_phase(12, 4, 32'hFFFF_FFFF);

        // Smallest table: one bucket, already taken, so adds are table-full.
        settle_and_write(qphs_pkg::CFG_BUCKET_COUNT, 13'd1);
        random_phase(6, 3, 32'hFFFF_FFFF);
        settle_and_write(qphs_pkg::CFG_BUCKET_COUNT, 13'd0);
        random_phase(4, 3, 32'hFFFF_FFFF);
        // Above range, treated as the maximum.
        settle_and_write(qphs_pkg::CFG_BUCKET_COUNT, 13'h1FF);
        random_phase(20, 8, 32'hFFFF_FFFF);

        // Small heap: no-space, append point past capacity, compares off the end.
        settle_and_write(qphs_pkg::CFG_HEAP_CAPACITY, 13'd0);
        random_phase(6, 3, 32'hFFFF_FFFF);
        settle_and_write(qphs_pkg::CFG_HEAP_CAPACITY, 13'h1FFF);
        settle_and_write(qphs_pkg::CFG_BUCKET_COUNT, 13'd7);
        random_phase(RANDOM_KEYS / 2, 6, 32'h0000_000F);
        settle_and_write(qphs_pkg::CFG_HEAP_CAPACITY, 13'd400);
        random_phase(60, 10, 32'hFFFF_FFFF);
        settle_and_write(qphs_pkg::CFG_BUCKET_COUNT, 13'd256);
        settle_and_write(qphs_pkg::CFG_HEAP_CAPACITY, 13'd4096);
        random_phase(RANDOM_KEYS / 2, 6, 32'hFFFF_FFFF);
        calm_tail = 1'b1;
        random_phase(40, 6, 32'hFFFF_FFFF);

        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
